// ===== hdl/lbp3_pkg.sv =====
// Shared constants for the 3x3 local binary pattern code map.
`timescale 1ns / 1ps

package lbp3_pkg;

   // Line buffer depth and frame height limit.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int POS_W  = 12;
   localparam int CFG_W  = 13;
   localparam int ADDR_W = $clog2(MAX_WIDTH);

   // Smallest frame dimension.
   localparam int MIN_SIZE = 3;

   // Register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(480);

endpackage

// ===== hdl/lbp_3x3_code_map.sv =====
// Streaming 3x3 local binary pattern code map with two line buffers.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  req_pixel, req_frame_start
// rsp       out  rsp_valid/rsp_ready  rsp_pattern_code, rsp_center_row,
//                                     rsp_center_col, rsp_frame_last
// csr       in   csr_wr_en            csr_index, csr_wr_data
//
// One pixel is taken per clock while the rsp side does not stall. A code is
// loaded into the output register after the transfer of the pixel below-right
// of its centre: the line buffer read and the stage 1 load share the transfer
// edge, the compares land in the output register when stage 1 advances.
// Reset is synchronous; it clears position, window and pipeline valids and
// loads the size registers with 640 x 480. Line buffer contents are undefined
// until written.
// A stalled rsp side holds the pipeline; req_ready stays high while the
// output register is empty or being drained.

module lbp_3x3_code_map (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lbp3_pkg::PIX_W-1:0]   req_pixel,
   input  logic                         req_frame_start,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lbp3_pkg::PIX_W-1:0]   rsp_pattern_code,
   output logic [lbp3_pkg::POS_W-1:0]   rsp_center_row,
   output logic [lbp3_pkg::POS_W-1:0]   rsp_center_col,
   output logic                         rsp_frame_last,

   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [lbp3_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int PIX_W  = lbp3_pkg::PIX_W;
   localparam int POS_W  = lbp3_pkg::POS_W;
   localparam int CFG_W  = lbp3_pkg::CFG_W;
   localparam int ADDR_W = lbp3_pkg::ADDR_W;

   // ---------------------------------------------------------------------
   // Size registers and their saturated values
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CFG_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lbp3_pkg::IMAGE_WIDTH_RESET;
         height_ff <= lbp3_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lbp3_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            lbp3_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < CFG_W'(lbp3_pkg::MIN_SIZE)) begin
         width_eff = CFG_W'(lbp3_pkg::MIN_SIZE);
      end else if (width_ff > CFG_W'(lbp3_pkg::MAX_WIDTH)) begin
         width_eff = CFG_W'(lbp3_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < CFG_W'(lbp3_pkg::MIN_SIZE)) begin
         height_eff = CFG_W'(lbp3_pkg::MIN_SIZE);
      end else if (height_ff > CFG_W'(lbp3_pkg::MAX_HEIGHT)) begin
         height_eff = CFG_W'(lbp3_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   // last column / row index, at least 2
   logic [CFG_W-1:0] col_last;
   logic [CFG_W-1:0] row_last;
   assign col_last = width_eff - CFG_W'(1);
   assign row_last = height_eff - CFG_W'(1);

   // ---------------------------------------------------------------------
   // Stage 0: position tracking and line buffer read
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [ADDR_W-1:0] addr;
      logic              emit;
      logic              last;
      logic [POS_W-1:0]  center_row;
      logic [POS_W-1:0]  center_col;
   } stage_type;

   logic             req_xfer;
   logic             s1_advance;
   logic             s1_valid_ff;
   stage_type        s1_ff;
   stage_type        s1_in;

   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] col_ff;
   logic [POS_W-1:0] row_cur;
   logic [POS_W-1:0] col_cur;
   logic [POS_W-1:0] row_in;
   logic [POS_W-1:0] col_in;
   logic [CFG_W-1:0] row_ext;
   logic [CFG_W-1:0] col_ext;
   logic [ADDR_W-1:0] rd_addr;

   assign req_xfer = req_valid && req_ready;

   assign row_cur = req_frame_start ? '0 : row_ff;
   assign col_cur = req_frame_start ? '0 : col_ff;
   assign row_ext = CFG_W'(row_cur);
   assign col_ext = CFG_W'(col_cur);

   always_comb begin
      if (col_ext >= col_last) begin
         col_in = '0;
         row_in = (row_ext >= row_last) ? '0 : row_cur + POS_W'(1);
      end else begin
         col_in = col_cur + POS_W'(1);
         row_in = row_cur;
      end
   end

   // guard against a column past the buffer depth
   assign rd_addr = (col_cur >= POS_W'(lbp3_pkg::MAX_WIDTH - 1)) ?
                    ADDR_W'(lbp3_pkg::MAX_WIDTH - 1) : ADDR_W'(col_cur);

   always_comb begin
      s1_in.pixel      = req_pixel;
      s1_in.addr       = rd_addr;
      s1_in.emit       = (row_cur >= POS_W'(2)) && (col_cur >= POS_W'(2)) &&
                         (row_ext < height_eff) && (col_ext < width_eff);
      s1_in.last       = (row_ext == row_last) && (col_ext == col_last);
      s1_in.center_row = row_cur - POS_W'(1);
      s1_in.center_col = col_cur - POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_xfer) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line buffers: one RAM word holds {upper, middle} for a column
   // ---------------------------------------------------------------------
   logic                 wr_en;
   logic [2*PIX_W-1:0]   wr_data;
   logic [2*PIX_W-1:0]   rd_data;
   logic [PIX_W-1:0]     top_pix;
   logic [PIX_W-1:0]     mid_pix;

   // write of the item leaving stage 1 may hit the address read this edge
   logic                 byp_ff;
   logic [2*PIX_W-1:0]   byp_data_ff;

   assign wr_en   = s1_advance;
   assign wr_data = {mid_pix, s1_ff.pixel};

   lbp3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (lbp3_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.addr),
      .wr_data (wr_data),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (req_xfer) begin
         byp_ff <= wr_en && (s1_ff.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         byp_data_ff <= wr_data;
      end
   end

   assign top_pix = byp_ff ? byp_data_ff[2*PIX_W-1:PIX_W] : rd_data[2*PIX_W-1:PIX_W];
   assign mid_pix = byp_ff ? byp_data_ff[PIX_W-1:0]       : rd_data[PIX_W-1:0];

   // ---------------------------------------------------------------------
   // Stage 1: window and compares
   // ---------------------------------------------------------------------
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     win_ff [6];
   logic [PIX_W-1:0]     center;
   logic [PIX_W-1:0]     code;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
   end

   // win 0..2: older column top/mid/bottom, 3..5: newer column
   assign center = win_ff[4];

   always_comb begin
      code[7] = win_ff[0]   >= center;
      code[6] = win_ff[3]   >= center;
      code[5] = top_pix     >= center;
      code[4] = mid_pix     >= center;
      code[3] = s1_ff.pixel >= center;
      code[2] = win_ff[5]   >= center;
      code[1] = win_ff[2]   >= center;
      code[0] = win_ff[1]   >= center;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= s1_ff.pixel;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0] code_ff;
   logic [POS_W-1:0] out_row_ff;
   logic [POS_W-1:0] out_col_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_ff.emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_ff.emit) begin
         code_ff     <= code;
         out_row_ff  <= s1_ff.center_row;
         out_col_ff  <= s1_ff.center_col;
         out_last_ff <= s1_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_code = code_ff;
   assign rsp_center_row   = out_row_ff;
   assign rsp_center_col   = out_col_ff;
   assign rsp_frame_last   = out_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_center_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_row != '0) && (rsp_center_col != '0))
      else $error("code emitted for a border pixel");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (col_ff == '0) || (col_ff == $past(col_cur) + POS_W'(1)))
      else $error("column position did not step by one");

   a_bypass_hold: assert property (@(posedge clock) disable iff (reset)
      req_xfer && wr_en && (s1_ff.addr == rd_addr) |=> byp_ff)
      else $error("line buffer bypass not set on a same-column write");

endmodule

// ===== hdl/lbp3_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module lbp3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
